@@ rtl/bfpb_pkg.sv @@
package bfpb_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FIELD_COORD_W  = 12;
    localparam int DIST_W         = 25;   // covers the widest root and rect distance
    localparam int FW_W           = 20;
    localparam int Q_W            = 16;   // strength quotient bits
    localparam int S_W            = 17;   // strength, 65536 = 1.0
    localparam int DATA_W         = 18;
    localparam int MEAN_W         = 17;
    localparam int CH_W           = 8;
    localparam int NUM_CH         = 4;

    localparam int MODE_SHAPE_BIT = 0;    // 0 circle, 1 rect
    localparam int MODE_QUAD_BIT  = 1;    // 0 linear, 1 quadratic

    localparam logic [S_W-1:0] S_ONE = S_W'(65536);

    typedef enum logic [1:0] {
        EFF_ADD    = 2'd0,
        EFF_SET    = 2'd1,
        EFF_SMOOTH = 2'd2,
        EFF_DATA   = 2'd3
    } effect_t;

    typedef enum logic [2:0] {
        REG_CENTER_X      = 3'd0,
        REG_CENTER_Y      = 3'd1,
        REG_RADIUS_X      = 3'd2,
        REG_RADIUS_Y      = 3'd3,
        REG_FALLOFF_WIDTH = 3'd4,
        REG_BRUSH_DATA    = 3'd5,
        REG_MEAN_LEVEL    = 3'd6,
        REG_MODE          = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [FIELD_COORD_W-1:0] center_x;
        logic [FIELD_COORD_W-1:0] center_y;
        logic [FW_W-1:0]          radius_x;
        logic [FW_W-1:0]          radius_y;
        logic [FW_W-1:0]          falloff_width;
        logic signed [DATA_W-1:0] brush_data;
        logic [MEAN_W-1:0]        mean_sat;   // already saturated to 1.0
        logic [3:0]               mode;
    } cfg_t;

    // pixel payload carried alongside the arithmetic
    typedef struct packed {
        logic [NUM_CH-1:0][CH_W-1:0] chans;
        logic [3:0]                  layer;
        logic [DIST_W-1:0]           rect_dist;
    } trail_t;

endpackage

@@ rtl/bfpb_geom.sv @@
module bfpb_geom #(
    parameter int COORD_BITS = bfpb_pkg::COORD_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [bfpb_pkg::FIELD_COORD_W-1:0]    pos_x,
    input  logic [bfpb_pkg::FIELD_COORD_W-1:0]    pos_y,
    input  bfpb_pkg::trail_t                      in_trail,
    input  bfpb_pkg::cfg_t                        cfg,
    output logic                                  out_valid,
    output logic [2*COORD_BITS-1:0]               out_sqx,
    output logic [2*COORD_BITS-1:0]               out_sqy,
    output bfpb_pkg::trail_t                      out_trail
);

    localparam int EX_W = COORD_BITS + 8;

    logic [COORD_BITS-1:0] px, py, cx, cy;
    logic [COORD_BITS-1:0] adx_next, ady_next;
    logic [COORD_BITS-1:0] adx_reg, ady_reg;
    logic                  v1_reg, v2_reg;
    bfpb_pkg::trail_t      t1_reg, t2_reg, t2_next;
    logic [2*COORD_BITS-1:0] sqx_reg, sqy_reg;
    logic [bfpb_pkg::DIST_W-1:0] exx, eyy, rx, ry, ex, ey;

    assign px = COORD_BITS'(pos_x);
    assign py = COORD_BITS'(pos_y);
    assign cx = COORD_BITS'(cfg.center_x);
    assign cy = COORD_BITS'(cfg.center_y);
    assign adx_next = (px >= cx) ? px - cx : cx - px;
    assign ady_next = (py >= cy) ? py - cy : cy - py;

    // rectangle distance from the registered deltas
    assign exx = bfpb_pkg::DIST_W'({adx_reg, 8'b0});
    assign eyy = bfpb_pkg::DIST_W'({ady_reg, 8'b0});
    assign rx  = bfpb_pkg::DIST_W'(cfg.radius_x);
    assign ry  = bfpb_pkg::DIST_W'(cfg.radius_y);
    assign ex  = (exx > rx) ? exx - rx : '0;
    assign ey  = (eyy > ry) ? eyy - ry : '0;

    always_comb begin
        t2_next = t1_reg;
        t2_next.rect_dist = (ex > ey) ? ex : ey;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            adx_reg <= adx_next;
            ady_reg <= ady_next;
            t1_reg  <= in_trail;
            sqx_reg <= adx_reg * adx_reg;
            sqy_reg <= ady_reg * ady_reg;
            t2_reg  <= t2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_sqx   = sqx_reg;
    assign out_sqy   = sqy_reg;
    assign out_trail = t2_reg;

endmodule

@@ rtl/bfpb_sqrt_pipe.sv @@
module bfpb_sqrt_pipe #(
    parameter int COORD_BITS = bfpb_pkg::COORD_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [2*COORD_BITS-1:0]   sqx,
    input  logic [2*COORD_BITS-1:0]   sqy,
    input  bfpb_pkg::trail_t          in_trail,
    output logic                      out_valid,
    output logic [COORD_BITS+8:0]     out_root,
    output bfpb_pkg::trail_t          out_trail
);

    // one root bit per stage, radicand is (dx^2 + dy^2) << 16
    localparam int SUM_W = 2*COORD_BITS + 1;
    localparam int STEPS = COORD_BITS + 9;
    localparam int N_W   = 2*STEPS;
    localparam int R_W   = STEPS;
    localparam int RM_W  = R_W + 3;

    logic [SUM_W-1:0] sum;
    logic [N_W-1:0]   n0;

    logic [N_W-1:0]   n_reg    [STEPS];
    logic [RM_W-1:0]  rem_reg  [STEPS];
    logic [R_W-1:0]   root_reg [STEPS];
    logic             valid_reg[STEPS];
    bfpb_pkg::trail_t trail_reg[STEPS];

    assign sum = SUM_W'(sqx) + SUM_W'(sqy);
    assign n0  = N_W'({sum, 16'b0});

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [N_W-1:0]   n_in, n_next;
        logic [RM_W-1:0]  rem_in, rem2, trial, rem_next;
        logic [R_W-1:0]   root_in, root_next;
        logic             v_in, ge;
        bfpb_pkg::trail_t t_in;

        if (k == 0) begin : g_first
            assign n_in    = n0;
            assign rem_in  = '0;
            assign root_in = '0;
            assign v_in    = in_valid;
            assign t_in    = in_trail;
        end else begin : g_rest
            assign n_in    = n_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign v_in    = valid_reg[k-1];
            assign t_in    = trail_reg[k-1];
        end

        assign rem2      = {rem_in[RM_W-3:0], n_in[N_W-1:N_W-2]};
        assign trial     = RM_W'({root_in, 2'b01});
        assign ge        = (rem2 >= trial);
        assign rem_next  = ge ? rem2 - trial : rem2;
        assign root_next = {root_in[R_W-2:0], ge};
        assign n_next    = n_in << 2;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k]     <= n_next;
                rem_reg[k]   <= rem_next;
                root_reg[k]  <= root_next;
                trail_reg[k] <= t_in;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_trail = trail_reg[STEPS-1];

endmodule

@@ rtl/bfpb_strength.sv @@
module bfpb_strength #(
    parameter int COORD_BITS = bfpb_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [COORD_BITS+8:0]         root,
    input  bfpb_pkg::trail_t              in_trail,
    input  bfpb_pkg::cfg_t                cfg,
    output logic                          out_valid,
    output logic [bfpb_pkg::S_W-1:0]      out_s,
    output bfpb_pkg::trail_t              out_trail
);

    localparam int DW = bfpb_pkg::DIST_W;
    localparam int FW = bfpb_pkg::FW_W;
    localparam int QW = bfpb_pkg::Q_W;

    logic [DW-1:0] root_d, rad_d, fw_d, circ, sel_dist;
    logic          v0_reg, full0_reg, zero0_reg;
    logic [FW-1:0] rem0_reg;
    bfpb_pkg::trail_t t0_reg;

    assign root_d   = DW'(root);
    assign rad_d    = DW'(cfg.radius_x);
    assign fw_d     = DW'(cfg.falloff_width);
    assign circ     = (root_d > rad_d) ? root_d - rad_d : '0;
    assign sel_dist = cfg.mode[bfpb_pkg::MODE_SHAPE_BIT] ? in_trail.rect_dist : circ;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            full0_reg <= (sel_dist == '0);
            zero0_reg <= (cfg.falloff_width == '0) || (sel_dist >= fw_d);
            rem0_reg  <= cfg.falloff_width - FW'(sel_dist);
            t0_reg    <= in_trail;
        end
    end

    // restoring divide: (fw - d) * 2^16 / fw, one quotient bit per stage
    logic [FW-1:0]    rem_reg  [QW];
    logic [QW-1:0]    q_reg    [QW];
    logic             full_reg [QW];
    logic             zero_reg [QW];
    logic             valid_reg[QW];
    bfpb_pkg::trail_t trail_reg[QW];

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [FW-1:0]    rem_in, rem_next;
        logic [FW:0]      r2;
        logic [QW-1:0]    q_in;
        logic             f_in, z_in, v_in, ge;
        bfpb_pkg::trail_t t_in;

        if (k == 0) begin : g_first
            assign rem_in = rem0_reg;
            assign q_in   = '0;
            assign f_in   = full0_reg;
            assign z_in   = zero0_reg;
            assign v_in   = v0_reg;
            assign t_in   = t0_reg;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign f_in   = full_reg[k-1];
            assign z_in   = zero_reg[k-1];
            assign v_in   = valid_reg[k-1];
            assign t_in   = trail_reg[k-1];
        end

        assign r2       = {rem_in, 1'b0};
        assign ge       = (r2 >= {1'b0, cfg.falloff_width});
        assign rem_next = ge ? FW'(r2 - {1'b0, cfg.falloff_width}) : FW'(r2);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]   <= rem_next;
                q_reg[k]     <= {q_in[QW-2:0], ge};
                full_reg[k]  <= f_in;
                zero_reg[k]  <= z_in;
                trail_reg[k] <= t_in;
            end
        end
    end

    logic [2*QW-1:0]            qq;
    logic [QW-1:0]              q_last;
    logic [bfpb_pkg::S_W-1:0]   s_next, s_reg;
    logic                       vs_reg;
    bfpb_pkg::trail_t           ts_reg;

    assign q_last = q_reg[QW-1];
    assign qq     = q_last * q_last;

    always_comb begin
        if (full_reg[QW-1]) begin
            s_next = bfpb_pkg::S_ONE;
        end else if (zero_reg[QW-1]) begin
            s_next = '0;
        end else if (cfg.mode[bfpb_pkg::MODE_QUAD_BIT]) begin
            s_next = bfpb_pkg::S_W'(qq[2*QW-1:QW]);
        end else begin
            s_next = bfpb_pkg::S_W'(q_last);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg <= 1'b0;
        end else if (en) begin
            vs_reg <= valid_reg[QW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg  <= s_next;
            ts_reg <= trail_reg[QW-1];
        end
    end

    assign out_valid = vs_reg;
    assign out_s     = s_reg;
    assign out_trail = ts_reg;

endmodule

@@ rtl/bfpb_blend.sv @@
module bfpb_blend (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              en,
    input  logic                                              in_valid,
    input  logic [bfpb_pkg::S_W-1:0]                          s,
    input  bfpb_pkg::trail_t                                  in_trail,
    input  bfpb_pkg::cfg_t                                    cfg,
    output logic                                              out_valid,
    output logic [bfpb_pkg::NUM_CH-1:0][bfpb_pkg::CH_W-1:0]   out_chans,
    output logic [1:0]                                        out_slice
);

    bfpb_pkg::effect_t effect;
    assign effect = bfpb_pkg::effect_t'(cfg.mode[3:2]);

    // B1: channel to Q1.16, data * s
    logic [7:0]             c;
    logic [16:0]            v_next, v1_reg, v2_reg;
    logic signed [35:0]     p1_next, p1_reg, p1b_reg;
    logic [16:0]            s1_reg;
    logic                   v1v_reg, v2v_reg, v3v_reg, vo_reg;
    bfpb_pkg::trail_t       t1_reg, t2_reg, t3_reg;

    assign c       = in_trail.chans[in_trail.layer[1:0]];
    assign v_next  = 17'({c, c}) + 17'(c[7]);
    assign p1_next = cfg.brush_data * $signed({1'b0, s});

    // B2: second product for set and smooth
    logic signed [19:0]     k;
    logic signed [18:0]     a_op;
    logic signed [19:0]     b_op;
    logic signed [38:0]     p2_reg;

    assign k = p1_reg[35:16];

    always_comb begin
        if (effect == bfpb_pkg::EFF_SET) begin
            a_op = 19'(cfg.brush_data) - $signed({2'b0, v1_reg});
            b_op = $signed({3'b0, s1_reg});
        end else begin
            a_op = $signed({2'b0, cfg.mean_sat}) - $signed({2'b0, v1_reg});
            b_op = k;
        end
    end

    // B3: pick term, add it to the channel (data replaces it), clamp to 0..1
    logic signed [24:0]     term, r_full;
    logic [16:0]            r_next, r_reg;

    always_comb begin
        case (effect)
            bfpb_pkg::EFF_ADD:  term = 25'($signed(p1b_reg[35:16]));
            bfpb_pkg::EFF_DATA: term = 25'(cfg.brush_data);
            default:            term = 25'($signed(p2_reg[38:16]));
        endcase
        if (effect == bfpb_pkg::EFF_DATA) begin
            r_full = term;
        end else begin
            r_full = $signed({8'b0, v2_reg}) + term;
        end
        if (r_full < 0) begin
            r_next = '0;
        end else if (r_full > 25'sd65536) begin
            r_next = bfpb_pkg::S_ONE;
        end else begin
            r_next = r_full[16:0];
        end
    end

    // B4: back to 8 bits, rounded
    logic [24:0] scaled;
    logic [bfpb_pkg::NUM_CH-1:0][bfpb_pkg::CH_W-1:0] chans_next, chans_reg;
    logic [1:0] slice_reg;

    assign scaled = {r_reg, 8'b0} - 25'(r_reg) + 25'd32768;

    always_comb begin
        chans_next = t3_reg.chans;
        chans_next[t3_reg.layer[1:0]] = scaled[23:16];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1v_reg <= 1'b0;
            v2v_reg <= 1'b0;
            v3v_reg <= 1'b0;
            vo_reg  <= 1'b0;
        end else if (en) begin
            v1v_reg <= in_valid;
            v2v_reg <= v1v_reg;
            v3v_reg <= v2v_reg;
            vo_reg  <= v3v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg    <= v_next;
            p1_reg    <= p1_next;
            s1_reg    <= s;
            t1_reg    <= in_trail;
            v2_reg    <= v1_reg;
            p1b_reg   <= p1_reg;
            p2_reg    <= a_op * b_op;
            t2_reg    <= t1_reg;
            r_reg     <= r_next;
            t3_reg    <= t2_reg;
            chans_reg <= chans_next;
            slice_reg <= t3_reg.layer[3:2];
        end
    end

    assign out_valid = vo_reg;
    assign out_chans = chans_reg;
    assign out_slice = slice_reg;

endmodule

@@ rtl/brush_falloff_pixel_blend_core.sv @@
// Channel  | Dir | Handshake              | Payload
// s_       | in  | s_tvalid / s_tready    | tdata: pos_x, pos_y, chan_0..3; tuser: layer
// m_       | out | m_tvalid / m_tready    | tdata: out_chan_0..3; tuser: slice
// cfg_     | in  | cfg_valid / cfg_ready  | cfg_index (register), cfg_data
//
// One item per cycle sustained while the m_ side does not stall. Stages:
// 2 geometry stages, one stage per root bit of the square root,
// 1 distance stage, 16 divider stages, 1 strength stage, 4 blend stages.
// aresetn is synchronous, active low; it clears valid bits and the config registers.
// A stalled m_ side freezes the whole pipeline and drops s_tready; nothing
// is lost or repeated. cfg_ready is always high.
module brush_falloff_pixel_blend_core #(
    parameter int COORD_BITS = bfpb_pkg::COORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // pos_x[11:0], pos_y[23:12], chan_0..chan_3 [55:24]
    input  logic [3:0]  s_tuser,   // layer[3:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_chan_0..out_chan_3, 8 bits each
    output logic [1:0]  m_tuser,   // slice[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    bfpb_pkg::cfg_t cfg;

    logic [11:0] center_x_reg, center_y_reg;
    logic [19:0] radius_x_reg, radius_y_reg, falloff_width_reg;
    logic signed [17:0] brush_data_reg;
    logic [16:0] mean_level_reg;
    logic [3:0]  mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg      <= '0;
            center_y_reg      <= '0;
            radius_x_reg      <= '0;
            radius_y_reg      <= '0;
            falloff_width_reg <= '0;
            brush_data_reg    <= '0;
            mean_level_reg    <= '0;
            mode_reg          <= '0;
        end else if (cfg_valid) begin
            unique case (bfpb_pkg::reg_idx_t'(cfg_index))
                bfpb_pkg::REG_CENTER_X:      center_x_reg      <= cfg_data[11:0];
                bfpb_pkg::REG_CENTER_Y:      center_y_reg      <= cfg_data[11:0];
                bfpb_pkg::REG_RADIUS_X:      radius_x_reg      <= cfg_data;
                bfpb_pkg::REG_RADIUS_Y:      radius_y_reg      <= cfg_data;
                bfpb_pkg::REG_FALLOFF_WIDTH: falloff_width_reg <= cfg_data;
                bfpb_pkg::REG_BRUSH_DATA:    brush_data_reg    <= cfg_data[17:0];
                bfpb_pkg::REG_MEAN_LEVEL:    mean_level_reg    <= cfg_data[16:0];
                bfpb_pkg::REG_MODE:          mode_reg          <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // mean above one is held at one
    always_comb begin
        cfg.center_x      = center_x_reg;
        cfg.center_y      = center_y_reg;
        cfg.radius_x      = radius_x_reg;
        cfg.radius_y      = radius_y_reg;
        cfg.falloff_width = falloff_width_reg;
        cfg.brush_data    = brush_data_reg;
        cfg.mean_sat      = (mean_level_reg > bfpb_pkg::S_ONE) ? bfpb_pkg::S_ONE
                                                               : mean_level_reg;
        cfg.mode          = mode_reg;
    end

    // global advance: every stage moves when the output slot is free or taken
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    bfpb_pkg::trail_t in_trail, g_trail, q_trail, st_trail;
    logic g_valid, q_valid, st_valid;
    logic [2*COORD_BITS-1:0] g_sqx, g_sqy;
    logic [COORD_BITS+8:0]   q_root;
    logic [bfpb_pkg::S_W-1:0] st_s;
    logic [bfpb_pkg::NUM_CH-1:0][bfpb_pkg::CH_W-1:0] o_chans;

    always_comb begin
        in_trail.chans     = s_tdata[55:24];
        in_trail.layer     = s_tuser;
        in_trail.rect_dist = '0;
    end

    bfpb_geom #(.COORD_BITS(COORD_BITS)) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .pos_x     (s_tdata[11:0]),
        .pos_y     (s_tdata[23:12]),
        .in_trail  (in_trail),
        .cfg       (cfg),
        .out_valid (g_valid),
        .out_sqx   (g_sqx),
        .out_sqy   (g_sqy),
        .out_trail (g_trail)
    );

    bfpb_sqrt_pipe #(.COORD_BITS(COORD_BITS)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (g_valid),
        .sqx       (g_sqx),
        .sqy       (g_sqy),
        .in_trail  (g_trail),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_trail (q_trail)
    );

    bfpb_strength #(.COORD_BITS(COORD_BITS)) u_strength (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (q_valid),
        .root      (q_root),
        .in_trail  (q_trail),
        .cfg       (cfg),
        .out_valid (st_valid),
        .out_s     (st_s),
        .out_trail (st_trail)
    );

    bfpb_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (st_valid),
        .s         (st_s),
        .in_trail  (st_trail),
        .cfg       (cfg),
        .out_valid (m_tvalid),
        .out_chans (o_chans),
        .out_slice (m_tuser)
    );

    assign m_tdata = o_chans;

endmodule

@@ rtl/bfpb_checker.sv @@
module bfpb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [55:0] s_tdata,
    input logic [3:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [19:0] cfg_data
);

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // a waiting item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("waiting item changed");

    // output back-pressure stops intake
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("item taken while output stalled");

    // free output slot means intake open
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready && cfg_ready)
        else $error("intake closed with empty output");

endmodule

bind brush_falloff_pixel_blend_core bfpb_checker u_bfpb_checker (.*);
